// ----- rtl/core/cvg_pkg.sv -----
// shared widths, constants and types of the circle vertex generator
// no dependencies; imported by every cvg module
package cvg_pkg;

  localparam int COORD_FRAC_BITS = 12;
  localparam int MAX_POINTS      = 4096;

  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int ANG_W   = 16;
  localparam int NUM_W   = IDX_W + ANG_W;
  localparam int ZSH     = 9;
  localparam int Z_W     = ANG_W + ZSH;
  localparam int XY_W    = 34;
  localparam int SC_W    = 32;
  localparam int COMP_W  = 25;
  localparam int SQ_W    = 48;
  localparam int ROOT_W  = SQ_W / 2;
  localparam int NRM_FRAC = 14;
  localparam int QN_W    = NRM_FRAC + 1;
  localparam int CORDIC_N = 16;

  localparam int FULL_TURN       = 46080;
  localparam int QUARTER_TURN    = 11520;
  localparam int CORDIC_GAIN_Q30 = 652032874;

  localparam logic signed [Z_W-1:0] ATAN_Q16 [0:CORDIC_N-1] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
    25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
    25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
    25'sd917,     25'sd458,     25'sd229,    25'sd115
  };

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } cvg_pos_t;

endpackage

// ----- rtl/core/cvg_angle.sv -----
// vertex angle: index * sweep / den, modulo a full turn, folded to a quadrant
// depends on cvg_pkg
module cvg_angle (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [cvg_pkg::IDX_W-1:0]         in_idx,
  input  logic [cvg_pkg::ANG_W-1:0]         sweep,
  input  logic [cvg_pkg::CNT_W-1:0]         den,
  output logic                              out_vld,
  output logic [1:0]                        out_quad,
  output logic signed [cvg_pkg::Z_W-1:0]    out_z
);
  import cvg_pkg::*;

  localparam int LAT = NUM_W + 2;

  logic [LAT-1:0]   vld_r;
  logic [NUM_W-1:0] num_r   [0:NUM_W];
  logic [CNT_W-1:0] rem_r   [0:NUM_W];
  logic [ANG_W-1:0] qm_r    [0:NUM_W];
  logic [NUM_W-1:0] num_nxt [0:NUM_W-1];
  logic [CNT_W-1:0] rem_nxt [0:NUM_W-1];
  logic [ANG_W-1:0] qm_nxt  [0:NUM_W-1];
  logic [CNT_W:0]   t_c     [0:NUM_W-1];
  logic [ANG_W:0]   q2_c    [0:NUM_W-1];
  logic             ge_c    [0:NUM_W-1];
  logic [1:0]       quad_nxt;
  logic [ANG_W-1:0] resid_c;
  logic [1:0]       quad_r;
  logic signed [Z_W-1:0] z_r;

  // one quotient bit per stage, quotient kept modulo a full turn
  always_comb begin
    for (int k = 0; k < NUM_W; k++) begin
      t_c[k]     = {rem_r[k], num_r[k][NUM_W-1]};
      ge_c[k]    = (t_c[k] >= {1'b0, den});
      rem_nxt[k] = ge_c[k] ? CNT_W'(t_c[k] - {1'b0, den}) : t_c[k][CNT_W-1:0];
      num_nxt[k] = {num_r[k][NUM_W-2:0], 1'b0};
      q2_c[k]    = {qm_r[k], ge_c[k]};
      qm_nxt[k]  = (q2_c[k] >= (ANG_W+1)'(FULL_TURN)) ?
                   ANG_W'(q2_c[k] - (ANG_W+1)'(FULL_TURN)) : q2_c[k][ANG_W-1:0];
    end
  end

  always_comb begin
    priority if (qm_r[NUM_W] >= ANG_W'(3 * QUARTER_TURN)) begin
      quad_nxt = 2'd3;
      resid_c  = qm_r[NUM_W] - ANG_W'(3 * QUARTER_TURN);
    end else if (qm_r[NUM_W] >= ANG_W'(2 * QUARTER_TURN)) begin
      quad_nxt = 2'd2;
      resid_c  = qm_r[NUM_W] - ANG_W'(2 * QUARTER_TURN);
    end else if (qm_r[NUM_W] >= ANG_W'(QUARTER_TURN)) begin
      quad_nxt = 2'd1;
      resid_c  = qm_r[NUM_W] - ANG_W'(QUARTER_TURN);
    end else begin
      quad_nxt = 2'd0;
      resid_c  = qm_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
    if (en) begin
      num_r[0] <= NUM_W'(in_idx) * NUM_W'(sweep);
      rem_r[0] <= '0;
      qm_r[0]  <= '0;
      for (int k = 0; k < NUM_W; k++) begin
        num_r[k+1] <= num_nxt[k];
        rem_r[k+1] <= rem_nxt[k];
        qm_r[k+1]  <= qm_nxt[k];
      end
      quad_r <= quad_nxt;
      z_r    <= $signed({resid_c, {ZSH{1'b0}}});
    end
  end

  assign out_vld  = vld_r[LAT-1];
  assign out_quad = quad_r;
  assign out_z    = z_r;

endmodule

// ----- rtl/core/cvg_cordic.sv -----
// pipelined rotation cordic, one iteration per stage, quadrant unfolding
// depends on cvg_pkg
module cvg_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic [1:0]                         in_quad,
  input  logic signed [cvg_pkg::Z_W-1:0]     in_z,
  output logic                               out_vld,
  output logic signed [cvg_pkg::SC_W-1:0]    out_sin,
  output logic signed [cvg_pkg::SC_W-1:0]    out_cos
);
  import cvg_pkg::*;

  localparam int LAT = CORDIC_N + 2;

  logic [LAT-1:0]         vld_r;
  logic signed [XY_W-1:0] x_r    [0:CORDIC_N];
  logic signed [XY_W-1:0] y_r    [0:CORDIC_N];
  logic signed [Z_W-1:0]  z_r    [0:CORDIC_N];
  logic [1:0]             quad_r [0:CORDIC_N];
  logic signed [XY_W-1:0] x_nxt  [0:CORDIC_N-1];
  logic signed [XY_W-1:0] y_nxt  [0:CORDIC_N-1];
  logic signed [Z_W-1:0]  z_nxt  [0:CORDIC_N-1];
  logic signed [XY_W-1:0] sin_c;
  logic signed [XY_W-1:0] cos_c;
  logic signed [SC_W-1:0] sin_r;
  logic signed [SC_W-1:0] cos_r;

  always_comb begin
    for (int k = 0; k < CORDIC_N; k++) begin
      if (z_r[k] >= 0) begin
        x_nxt[k] = x_r[k] - (y_r[k] >>> k);
        y_nxt[k] = y_r[k] + (x_r[k] >>> k);
        z_nxt[k] = z_r[k] - ATAN_Q16[k];
      end else begin
        x_nxt[k] = x_r[k] + (y_r[k] >>> k);
        y_nxt[k] = y_r[k] - (x_r[k] >>> k);
        z_nxt[k] = z_r[k] + ATAN_Q16[k];
      end
    end
  end

  always_comb begin
    unique case (quad_r[CORDIC_N])
      2'd0: begin
        sin_c = y_r[CORDIC_N];
        cos_c = x_r[CORDIC_N];
      end
      2'd1: begin
        sin_c = x_r[CORDIC_N];
        cos_c = -y_r[CORDIC_N];
      end
      2'd2: begin
        sin_c = -y_r[CORDIC_N];
        cos_c = -x_r[CORDIC_N];
      end
      default: begin
        sin_c = -x_r[CORDIC_N];
        cos_c = y_r[CORDIC_N];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
    if (en) begin
      x_r[0]    <= XY_W'(CORDIC_GAIN_Q30);
      y_r[0]    <= '0;
      z_r[0]    <= in_z;
      quad_r[0] <= in_quad;
      for (int k = 0; k < CORDIC_N; k++) begin
        x_r[k+1]    <= x_nxt[k];
        y_r[k+1]    <= y_nxt[k];
        z_r[k+1]    <= z_nxt[k];
        quad_r[k+1] <= quad_r[k];
      end
      sin_r <= sin_c[SC_W-1:0];
      cos_r <= cos_c[SC_W-1:0];
    end
  end

  assign out_vld = vld_r[LAT-1];
  assign out_sin = sin_r;
  assign out_cos = cos_r;

endmodule

// ----- rtl/core/cvg_norm.sv -----
// normal normalization: squares, pipelined square root, three-lane divider
// depends on cvg_pkg
module cvg_norm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  cvg_pkg::cvg_pos_t                  in_pos,
  input  logic signed [cvg_pkg::COMP_W-1:0]  in_ax,
  input  logic signed [cvg_pkg::COMP_W-1:0]  in_ay,
  input  logic signed [cvg_pkg::COMP_W-1:0]  in_az,
  output logic                               out_vld,
  output cvg_pkg::cvg_pos_t                  out_pos,
  output logic signed [15:0]                 out_nx,
  output logic signed [15:0]                 out_ny,
  output logic signed [15:0]                 out_nz
);
  import cvg_pkg::*;

  localparam int S_PREP = ROOT_W + 2;
  localparam int LAT    = S_PREP + QN_W + 2;
  localparam int RR_W   = ROOT_W + 2;
  localparam int N_W    = ROOT_W + NRM_FRAC + 1;
  localparam logic [QN_W-1:0] Q_ONE = QN_W'(1 << NRM_FRAC);

  logic [LAT-1:0]           vld_r;
  cvg_pos_t                 pos_r  [0:LAT-1];
  logic signed [COMP_W-1:0] a_r    [0:S_PREP-1][0:2];
  logic [SQ_W-1:0]          sq_r   [0:2];
  logic [SQ_W-1:0]          rv_r   [0:ROOT_W];
  logic [RR_W-1:0]          rr_r   [0:ROOT_W];
  logic [ROOT_W-1:0]        root_r [0:ROOT_W];
  logic [ROOT_W-1:0]        len_r  [0:QN_W];
  logic [QN_W-1:0]          dn_r   [0:QN_W][0:2];
  logic [ROOT_W-1:0]        drem_r [0:QN_W][0:2];
  logic [QN_W-1:0]          q_r    [0:QN_W][0:2];
  logic                     neg_r  [0:QN_W][0:2];
  logic signed [15:0]       n_r    [0:2];

  logic signed [2*COMP_W-1:0] sqf_c [0:2];
  logic [RR_W+1:0]          st_c    [0:ROOT_W-1];
  logic [RR_W+1:0]          stest_c [0:ROOT_W-1];
  logic                     sge_c   [0:ROOT_W-1];
  logic [RR_W-1:0]          rr_nxt  [0:ROOT_W-1];
  logic [COMP_W-1:0]        mag_c   [0:2];
  logic [N_W-1:0]           nfull_c [0:2];
  logic [ROOT_W:0]          dt_c    [0:QN_W-1][0:2];
  logic                     dge_c   [0:QN_W-1][0:2];
  logic [ROOT_W-1:0]        drem_nxt [0:QN_W-1][0:2];
  logic [QN_W-1:0]          qc_c    [0:2];
  logic signed [15:0]       n_nxt   [0:2];

  always_comb begin
    sqf_c[0] = in_ax * in_ax;
    sqf_c[1] = in_ay * in_ay;
    sqf_c[2] = in_az * in_az;
  end

  // digit-by-digit square root, two radicand bits per stage
  always_comb begin
    for (int j = 0; j < ROOT_W; j++) begin
      st_c[j]    = {rr_r[j], rv_r[j][SQ_W-1:SQ_W-2]};
      stest_c[j] = {2'b00, root_r[j], 2'b01};
      sge_c[j]   = (st_c[j] >= stest_c[j]);
      rr_nxt[j]  = sge_c[j] ? RR_W'(st_c[j] - stest_c[j]) : st_c[j][RR_W-1:0];
    end
  end

  // rounded magnitude numerator, half away from zero
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_c[l]   = (a_r[S_PREP-1][l] < 0) ? COMP_W'(-a_r[S_PREP-1][l]) :
                   COMP_W'(a_r[S_PREP-1][l]);
      nfull_c[l] = {1'b0, mag_c[l][ROOT_W-1:0], {NRM_FRAC{1'b0}}} +
                   N_W'(root_r[ROOT_W] >> 1);
    end
  end

  always_comb begin
    for (int k = 0; k < QN_W; k++) begin
      for (int l = 0; l < 3; l++) begin
        dt_c[k][l]     = {drem_r[k][l], dn_r[k][l][QN_W-1]};
        dge_c[k][l]    = (dt_c[k][l] >= {1'b0, len_r[k]});
        drem_nxt[k][l] = dge_c[k][l] ? ROOT_W'(dt_c[k][l] - {1'b0, len_r[k]}) :
                         dt_c[k][l][ROOT_W-1:0];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qc_c[l] = (q_r[QN_W][l] > Q_ONE) ? Q_ONE : q_r[QN_W][l];
      if (len_r[QN_W] == '0) begin
        n_nxt[l] = '0;
      end else if (neg_r[QN_W][l]) begin
        n_nxt[l] = -$signed({1'b0, qc_c[l]});
      end else begin
        n_nxt[l] = $signed({1'b0, qc_c[l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
    if (en) begin
      pos_r[0] <= in_pos;
      for (int i = 1; i < LAT; i++) begin
        pos_r[i] <= pos_r[i-1];
      end
      a_r[0][0] <= in_ax;
      a_r[0][1] <= in_ay;
      a_r[0][2] <= in_az;
      for (int i = 1; i < S_PREP; i++) begin
        for (int l = 0; l < 3; l++) begin
          a_r[i][l] <= a_r[i-1][l];
        end
      end
      for (int l = 0; l < 3; l++) begin
        sq_r[l] <= sqf_c[l][SQ_W-1:0];
      end
      rv_r[0]   <= sq_r[0] + sq_r[1] + sq_r[2];
      rr_r[0]   <= '0;
      root_r[0] <= '0;
      for (int j = 0; j < ROOT_W; j++) begin
        rv_r[j+1]   <= {rv_r[j][SQ_W-3:0], 2'b00};
        rr_r[j+1]   <= rr_nxt[j];
        root_r[j+1] <= {root_r[j][ROOT_W-2:0], sge_c[j]};
      end
      len_r[0] <= root_r[ROOT_W];
      for (int l = 0; l < 3; l++) begin
        drem_r[0][l] <= nfull_c[l][N_W-1:QN_W];
        dn_r[0][l]   <= nfull_c[l][QN_W-1:0];
        q_r[0][l]    <= '0;
        neg_r[0][l]  <= (a_r[S_PREP-1][l] < 0);
      end
      for (int k = 0; k < QN_W; k++) begin
        len_r[k+1] <= len_r[k];
        for (int l = 0; l < 3; l++) begin
          drem_r[k+1][l] <= drem_nxt[k][l];
          dn_r[k+1][l]   <= {dn_r[k][l][QN_W-2:0], 1'b0};
          q_r[k+1][l]    <= {q_r[k][l][QN_W-2:0], dge_c[k][l]};
          neg_r[k+1][l]  <= neg_r[k][l];
        end
      end
      for (int l = 0; l < 3; l++) begin
        n_r[l] <= n_nxt[l];
      end
    end
  end

  assign out_vld = vld_r[LAT-1];
  assign out_pos = pos_r[LAT-1];
  assign out_nx  = n_r[0];
  assign out_ny  = n_r[1];
  assign out_nz  = n_r[2];

endmodule

// ----- rtl/core/circle_vertex_generator_3d_unit.sv -----
// circle and arc vertex generator: one vertex per request, position, texture and normal
// depends on cvg_pkg, cvg_angle, cvg_cordic and cvg_norm

// Takes one vertex index per cycle and returns the vertex (r*sin, r*cos, plane_z) of a
// tessellated circle or arc, with optional texture coordinates and an optional normal.
// The chain of bit-serial stages runs through 28 angle-divider stages, 16 cordic stages,
// 24 square-root stages and 15 stages of the normal divider. Throughput is one request
// per cycle; a stall on the output freezes the whole pipeline, and in_ready falls only while
// a result waits in the output register.
// Configuration must only be written while no request is in flight.
module circle_vertex_generator_3d_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cvg_pkg::IDX_W-1:0]  in_vertex_index,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [15:0]         out_pos_x,
  output logic signed [15:0]         out_pos_y,
  output logic signed [15:0]         out_pos_z,
  output logic signed [15:0]         out_tex_u,
  output logic signed [15:0]         out_tex_v,
  output logic                       out_tex_valid,
  output logic signed [15:0]         out_norm_x,
  output logic signed [15:0]         out_norm_y,
  output logic signed [15:0]         out_norm_z,
  output logic                       out_norm_valid,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_data
);
  import cvg_pkg::*;

  typedef enum logic [2:0] {
    CFG_POINT_COUNT    = 3'd0,
    CFG_RADIUS         = 3'd1,
    CFG_SWEEP_ANGLE    = 3'd2,
    CFG_PLANE_Z        = 3'd3,
    CFG_NORMAL_MODE    = 3'd4,
    CFG_NORMAL_Z       = 3'd5,
    CFG_TEXTURE_ENABLE = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    NM_NONE   = 4'd0,
    NM_POS_X  = 4'd1,
    NM_NEG_X  = 4'd2,
    NM_POS_Y  = 4'd3,
    NM_NEG_Y  = 4'd4,
    NM_POS_Z  = 4'd5,
    NM_NEG_Z  = 4'd6,
    NM_CIRC   = 4'd7,
    NM_CIRC_N = 4'd8,
    NM_CIRC_R = 4'd9,
    NM_CIRC_L = 4'd10
  } nmode_t;

  localparam int PROD_W = SC_W + 17;
  localparam int XR_W   = PROD_W - 29;
  localparam int S20_W  = SC_W - 9;
  localparam int NZ_SH  = 20 - COORD_FRAC_BITS;
  localparam logic signed [15:0] N_ONE = 16'sd16384;
  localparam logic signed [XR_W:0] HALF = (XR_W+1)'(1 << (COORD_FRAC_BITS - 1));

  // configuration registers
  logic [CNT_W-1:0]   point_count_r;
  logic [15:0]        radius_r;
  logic [ANG_W-1:0]   sweep_angle_r;
  logic signed [15:0] plane_z_r;
  logic [3:0]         normal_mode_r;
  logic signed [15:0] normal_z_r;
  logic               texture_enable_r;

  // pipeline advance: everything moves unless a result is stuck at the output
  logic en;
  logic req_acc;

  logic [CNT_W-1:0] cnt_c;
  logic [CNT_W-1:0] den_c;

  logic                   ang_vld;
  logic [1:0]             ang_quad;
  logic signed [Z_W-1:0]  ang_z;
  logic                   sc_vld;
  logic signed [SC_W-1:0] sc_sin;
  logic signed [SC_W-1:0] sc_cos;

  // scale stage one: radius products and rounded Q20 sin/cos
  logic                     m1_vld_r;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic signed [S20_W-1:0]  s20_r;
  logic signed [S20_W-1:0]  c20_r;
  logic signed [SC_W:0]     s_rnd_c;
  logic signed [SC_W:0]     c_rnd_c;

  // scale stage two: rounded position, texture and normal components
  logic                     m2_vld_r;
  cvg_pos_t                 pos_r;
  logic signed [COMP_W-1:0] ax_r;
  logic signed [COMP_W-1:0] ay_r;
  logic signed [COMP_W-1:0] az_r;
  logic signed [PROD_W:0]   px_c;
  logic signed [PROD_W:0]   py_c;
  logic signed [XR_W-1:0]   xr_c;
  logic signed [XR_W-1:0]   yr_c;
  logic signed [XR_W:0]     tu_c;
  logic signed [XR_W:0]     tv_c;
  logic signed [COMP_W-1:0] sx_c;
  logic signed [COMP_W-1:0] cx_c;
  logic signed [COMP_W-1:0] ax_nxt;
  logic signed [COMP_W-1:0] ay_nxt;
  cvg_pos_t                 pos_nxt;

  logic                   nrm_vld;
  cvg_pos_t               nrm_pos;
  logic signed [15:0]     nrm_x;
  logic signed [15:0]     nrm_y;
  logic signed [15:0]     nrm_z;

  // output register
  logic               out_valid_r;
  cvg_pos_t           out_pos_r;
  logic signed [15:0] out_pos_z_r;
  logic               out_tex_valid_r;
  logic signed [15:0] out_nx_r;
  logic signed [15:0] out_ny_r;
  logic signed [15:0] out_nz_r;
  logic               out_nv_r;
  logic signed [15:0] nx_nxt;
  logic signed [15:0] ny_nxt;
  logic signed [15:0] nz_nxt;
  logic               nv_nxt;

  function automatic logic signed [15:0] sat16(input logic signed [XR_W:0] v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign req_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r    <= CNT_W'(16);
      radius_r         <= 16'd2048;
      sweep_angle_r    <= ANG_W'(FULL_TURN);
      plane_z_r        <= '0;
      normal_mode_r    <= NM_NONE;
      normal_z_r       <= '0;
      texture_enable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POINT_COUNT:    point_count_r    <= cfg_data[CNT_W-1:0];
        CFG_RADIUS:         radius_r         <= cfg_data;
        CFG_SWEEP_ANGLE:    sweep_angle_r    <= cfg_data[ANG_W-1:0];
        CFG_PLANE_Z:        plane_z_r        <= $signed(cfg_data);
        CFG_NORMAL_MODE:    normal_mode_r    <= cfg_data[3:0];
        CFG_NORMAL_Z:       normal_z_r       <= $signed(cfg_data);
        CFG_TEXTURE_ENABLE: texture_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp the point count, closed circle divides by count, open arc by count - 1
  always_comb begin
    priority if (point_count_r < CNT_W'(2)) begin
      cnt_c = CNT_W'(2);
    end else if (point_count_r > CNT_W'(MAX_POINTS)) begin
      cnt_c = CNT_W'(MAX_POINTS);
    end else begin
      cnt_c = point_count_r;
    end
    den_c = (sweep_angle_r == ANG_W'(FULL_TURN)) ? cnt_c : cnt_c - CNT_W'(1);
  end

  cvg_angle u_angle (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (req_acc),
    .in_idx   (in_vertex_index),
    .sweep    (sweep_angle_r),
    .den      (den_c),
    .out_vld  (ang_vld),
    .out_quad (ang_quad),
    .out_z    (ang_z)
  );

  cvg_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (ang_vld),
    .in_quad (ang_quad),
    .in_z    (ang_z),
    .out_vld (sc_vld),
    .out_sin (sc_sin),
    .out_cos (sc_cos)
  );

  // round half up into Q20 for the normal path
  always_comb begin
    s_rnd_c = {sc_sin[SC_W-1], sc_sin} + (SC_W+1)'(512);
    c_rnd_c = {sc_cos[SC_W-1], sc_cos} + (SC_W+1)'(512);
  end

  // position rounding, texture offsets and circle normal selection
  always_comb begin
    px_c   = {prod_x_r[PROD_W-1], prod_x_r} + (PROD_W+1)'(64'd536870912);
    py_c   = {prod_y_r[PROD_W-1], prod_y_r} + (PROD_W+1)'(64'd536870912);
    xr_c   = px_c[PROD_W:30];
    yr_c   = py_c[PROD_W:30];
    tu_c   = HALF + (XR_W+1)'(xr_c);
    tv_c   = HALF - (XR_W+1)'(yr_c);
    sx_c   = COMP_W'(s20_r);
    cx_c   = COMP_W'(c20_r);
    pos_nxt.pos_x = sat16((XR_W+1)'(xr_c));
    pos_nxt.pos_y = sat16((XR_W+1)'(yr_c));
    pos_nxt.tex_u = sat16(tu_c);
    pos_nxt.tex_v = sat16(tv_c);
    unique case (normal_mode_r)
      NM_CIRC_N: begin
        ax_nxt = -sx_c;
        ay_nxt = -cx_c;
      end
      NM_CIRC_R: begin
        ax_nxt = cx_c;
        ay_nxt = -sx_c;
      end
      NM_CIRC_L: begin
        ax_nxt = -cx_c;
        ay_nxt = sx_c;
      end
      default: begin
        ax_nxt = sx_c;
        ay_nxt = cx_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= sc_vld;
      m2_vld_r <= m1_vld_r;
    end
    if (en) begin
      prod_x_r <= $signed({1'b0, radius_r}) * sc_sin;
      prod_y_r <= $signed({1'b0, radius_r}) * sc_cos;
      s20_r    <= s_rnd_c[SC_W:10];
      c20_r    <= c_rnd_c[SC_W:10];
      pos_r    <= pos_nxt;
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      az_r     <= COMP_W'($signed({normal_z_r, {NZ_SH{1'b0}}}));
    end
  end

  cvg_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (m2_vld_r),
    .in_pos  (pos_r),
    .in_ax   (ax_r),
    .in_ay   (ay_r),
    .in_az   (az_r),
    .out_vld (nrm_vld),
    .out_pos (nrm_pos),
    .out_nx  (nrm_x),
    .out_ny  (nrm_y),
    .out_nz  (nrm_z)
  );

  // final normal by mode; axis modes are constants, NM_NONE and unknown modes give no normal
  always_comb begin
    nx_nxt = '0;
    ny_nxt = '0;
    nz_nxt = '0;
    nv_nxt = 1'b1;
    unique case (normal_mode_r)
      NM_POS_X: nx_nxt = N_ONE;
      NM_NEG_X: nx_nxt = -N_ONE;
      NM_POS_Y: ny_nxt = N_ONE;
      NM_NEG_Y: ny_nxt = -N_ONE;
      NM_POS_Z: nz_nxt = N_ONE;
      NM_NEG_Z: nz_nxt = -N_ONE;
      NM_CIRC, NM_CIRC_N, NM_CIRC_R, NM_CIRC_L: begin
        nx_nxt = nrm_x;
        ny_nxt = nrm_y;
        nz_nxt = nrm_z;
      end
      default: nv_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= nrm_vld;
    end
    if (en) begin
      out_pos_r.pos_x <= nrm_pos.pos_x;
      out_pos_r.pos_y <= nrm_pos.pos_y;
      out_pos_r.tex_u <= texture_enable_r ? nrm_pos.tex_u : '0;
      out_pos_r.tex_v <= texture_enable_r ? nrm_pos.tex_v : '0;
      out_tex_valid_r <= texture_enable_r;
      out_pos_z_r     <= plane_z_r;
      out_nx_r        <= nx_nxt;
      out_ny_r        <= ny_nxt;
      out_nz_r        <= nz_nxt;
      out_nv_r        <= nv_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = out_pos_r.pos_x;
  assign out_pos_y      = out_pos_r.pos_y;
  assign out_pos_z      = out_pos_z_r;
  assign out_tex_u      = out_pos_r.tex_u;
  assign out_tex_v      = out_pos_r.tex_v;
  assign out_tex_valid  = out_tex_valid_r;
  assign out_norm_x     = out_nx_r;
  assign out_norm_y     = out_ny_r;
  assign out_norm_z     = out_nz_r;
  assign out_norm_valid = out_nv_r;

  // texture disabled leaves zero coordinates
  a_tex_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tex_valid_r |-> out_pos_r.tex_u == 0 && out_pos_r.tex_v == 0)
    else $error("texture coordinates set while texture is off");

  // no normal means all components zero
  a_norm_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_nv_r |-> out_nx_r == 0 && out_ny_r == 0 && out_nz_r == 0)
    else $error("normal components set without a normal");

  // normal components stay within unit range
  a_norm_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_nx_r <= N_ONE && out_nx_r >= -N_ONE &&
                    out_ny_r <= N_ONE && out_ny_r >= -N_ONE &&
                    out_nz_r <= N_ONE && out_nz_r >= -N_ONE)
    else $error("normal component out of range");

endmodule

// ----- test/circle_vertex_generator_3d_unit_test.sv -----
// self-checking testbench for circle_vertex_generator_3d_unit: directed and random vertex requests
// depends on cvg_pkg and the circle_vertex_generator_3d_unit rtl
`timescale 1ns / 1ps

module circle_vertex_generator_3d_unit_test;
  import cvg_pkg::*;

  // register indexes on the cfg port
  localparam logic [2:0] REG_POINT_COUNT = 3'd0;
  localparam logic [2:0] REG_RADIUS      = 3'd1;
  localparam logic [2:0] REG_SWEEP       = 3'd2;
  localparam logic [2:0] REG_PLANE_Z     = 3'd3;
  localparam logic [2:0] REG_NORMAL_MODE = 3'd4;
  localparam logic [2:0] REG_NORMAL_Z    = 3'd5;
  localparam logic [2:0] REG_TEXTURE_EN  = 3'd6;

  // normal modes
  localparam logic [3:0] NRM_NONE    = 4'd0;
  localparam logic [3:0] NRM_POS_X   = 4'd1;
  localparam logic [3:0] NRM_NEG_X   = 4'd2;
  localparam logic [3:0] NRM_POS_Y   = 4'd3;
  localparam logic [3:0] NRM_NEG_Y   = 4'd4;
  localparam logic [3:0] NRM_POS_Z   = 4'd5;
  localparam logic [3:0] NRM_NEG_Z   = 4'd6;
  localparam logic [3:0] NRM_SC      = 4'd7;
  localparam logic [3:0] NRM_NEG_SC  = 4'd8;
  localparam logic [3:0] NRM_CS      = 4'd9;
  localparam logic [3:0] NRM_NEG_CS  = 4'd10;

  localparam int IDLE_PCT     = 34;
  localparam int STALL_LIMIT  = 5000;  // cycles with no handshake at all
  localparam int TAIL_CYCLES  = 150;

  typedef struct {
    logic [15:0] pos_x, pos_y, pos_z, tex_u, tex_v;
    logic        tex_valid;
    logic [15:0] norm_x, norm_y, norm_z;
    logic        norm_valid;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IDX_W-1:0] in_vertex_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic out_tex_valid, out_norm_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  circle_vertex_generator_3d_unit dut (.*);

  // mirror of the block's registers
  longint     pcount_q, radius_q, sweep_q, plane_z_q, nmode_q, normal_z_q, tex_en_q;

  vertex_t    pending_vertices[$];
  int         errors = 0;
  int         requests_sent = 0;
  int         vertices_checked = 0;
  int         hold_off_cycles = 0;   // receiver holds out_ready low while nonzero
  bit         steady = 0;            // no random idling on either side

  initial forever #10 clk = ~clk;

  // watchdog: any cycle with a handshake resets the count
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else if (steady || !rst_n) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic logic [15:0] sat16(longint v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7fff;
    return v[15:0];
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < -16384) return -16384;
    if (v > 16384) return 16384;
    return v;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // expected vertex for one index under the current register mirror
  function automatic vertex_t vertex_for_index(logic [IDX_W-1:0] idx);
    vertex_t v;
    longint cnt, den, ang, quad, z, x, y, dx, dy, s30, c30, xr, yr;
    longint s20, c20, ax, ay, az, len, nx, ny, nz;
    bit nvalid;
    cnt = pcount_q;
    if (cnt < 2) cnt = 2;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    den = (sweep_q == FULL_TURN) ? cnt : cnt - 1;
    ang = (longint'(idx) * sweep_q / den) % FULL_TURN;
    // first-quadrant cordic, then fold into the right quadrant
    quad = ang / QUARTER_TURN;
    z = (ang % QUARTER_TURN) * 512;
    x = CORDIC_GAIN_Q30;
    y = 0;
    for (int k = 0; k < CORDIC_N; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q16[k]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q16[k]);
      end
    end
    case (quad & 3)
      0: begin s30 = y;  c30 = x;  end
      1: begin s30 = x;  c30 = -y; end
      2: begin s30 = -y; c30 = -x; end
      default: begin s30 = -x; c30 = y; end
    endcase
    xr = (radius_q * s30 + (64'sd1 << 29)) >>> 30;
    yr = (radius_q * c30 + (64'sd1 << 29)) >>> 30;

    nx = 0; ny = 0; nz = 0; nvalid = 1;
    case (nmode_q[3:0])
      NRM_POS_X: nx = 16384;
      NRM_NEG_X: nx = -16384;
      NRM_POS_Y: ny = 16384;
      NRM_NEG_Y: ny = -16384;
      NRM_POS_Z: nz = 16384;
      NRM_NEG_Z: nz = -16384;
      NRM_SC, NRM_NEG_SC, NRM_CS, NRM_NEG_CS: begin
        s20 = (s30 + 512) >>> 10;
        c20 = (c30 + 512) >>> 10;
        az = normal_z_q * (64'sd1 << (20 - COORD_FRAC_BITS));
        case (nmode_q[3:0])
          NRM_SC:     begin ax = s20;  ay = c20;  end
          NRM_NEG_SC: begin ax = -s20; ay = -c20; end
          NRM_CS:     begin ax = c20;  ay = -s20; end
          default:    begin ax = -c20; ay = s20;  end
        endcase
        len = floor_sqrt(ax * ax + ay * ay + az * az);
        if (len > 0) begin
          nx = clamp_unit(round_div(ax * 16384, len));
          ny = clamp_unit(round_div(ay * 16384, len));
          nz = clamp_unit(round_div(az * 16384, len));
        end
      end
      default: nvalid = 0;
    endcase

    v.pos_x = sat16(xr);
    v.pos_y = sat16(yr);
    v.pos_z = plane_z_q[15:0];
    v.tex_u = tex_en_q ? sat16(2048 + xr) : 16'h0;
    v.tex_v = tex_en_q ? sat16(2048 - yr) : 16'h0;
    v.tex_valid = tex_en_q[0];
    v.norm_x = nx[15:0];
    v.norm_y = ny[15:0];
    v.norm_z = nz[15:0];
    v.norm_valid = nvalid;
    return v;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d (0x%04h), got %0d (0x%04h)",
             name, $signed(want), want, $signed(got), got);
      errors++;
    end
  endfunction

  // result checker: values sampled before the edge's updates land
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex: x=%0d y=%0d", out_pos_x, out_pos_y);
        errors++;
      end else begin
        want = pending_vertices.pop_front();
        compare_field("pos_x", want.pos_x, out_pos_x);
        compare_field("pos_y", want.pos_y, out_pos_y);
        compare_field("pos_z", want.pos_z, out_pos_z);
        compare_field("tex_u", want.tex_u, out_tex_u);
        compare_field("tex_v", want.tex_v, out_tex_v);
        compare_field("tex_valid", {15'd0, want.tex_valid}, {15'd0, out_tex_valid});
        compare_field("norm_x", want.norm_x, out_norm_x);
        compare_field("norm_y", want.norm_y, out_norm_y);
        compare_field("norm_z", want.norm_z, out_norm_z);
        compare_field("norm_valid", {15'd0, want.norm_valid}, {15'd0, out_norm_valid});
        vertices_checked++;
      end
    end
  end

  // one request; valid stays high into the next request unless the sender idles
  task automatic send_index(logic [IDX_W-1:0] idx);
    in_valid <= 1'b1;
    in_vertex_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_vertices.insert(pending_vertices.size(), vertex_for_index(idx));
    requests_sent++;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
  endtask

  // register write; cfg_valid stays high across back-to-back writes
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_POINT_COUNT: pcount_q = longint'(value & 16'h1fff);
      REG_RADIUS:      radius_q = longint'(value);
      REG_SWEEP:       sweep_q = longint'(value);
      REG_PLANE_Z:     plane_z_q = longint'($signed(value));
      REG_NORMAL_MODE: nmode_q = longint'(value & 16'hf);
      REG_NORMAL_Z:    normal_z_q = longint'($signed(value));
      REG_TEXTURE_EN:  tex_en_q = longint'(value & 16'h1);
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] pc, logic [15:0] rad, logic [15:0] sweep,
                           logic [15:0] pz, logic [3:0] mode, logic [15:0] nzv, logic ten);
    drain();
    write_reg(REG_POINT_COUNT, pc);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_SWEEP, sweep);
    write_reg(REG_PLANE_Z, pz);
    write_reg(REG_NORMAL_MODE, {12'd0, mode});
    write_reg(REG_NORMAL_Z, nzv);
    write_reg(REG_TEXTURE_EN, {15'd0, ten});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config;
    logic [15:0] pc, sweep;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) pc = 16'($urandom_range(2, 64));
    else if (pick < 9) pc = 16'($urandom_range(2, 4096));
    else pc = 16'($urandom_range(0, 8191));  // clamped below two and above the maximum
    pick = $urandom_range(0, 3);
    sweep = (pick == 0) ? 16'(FULL_TURN) : (pick == 1) ? 16'($urandom_range(0, FULL_TURN))
                                                       : 16'($urandom);
    configure(pc, 16'($urandom), sweep, 16'($urandom), 4'($urandom_range(0, 15)),
              16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // mostly indices on the arc, the rest anywhere in the index range, so some past its end
  function automatic logic [IDX_W-1:0] random_index;
    longint cnt;
    cnt = (pcount_q < 2) ? 2 : (pcount_q > MAX_POINTS) ? MAX_POINTS : pcount_q;
    if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, cnt - 1));
    return IDX_W'($urandom);
  endfunction

  // reset values: closed 16-point circle, radius 0.5, no texture, no normal
  task automatic test_reset_defaults;
    pcount_q = 16; radius_q = 2048; sweep_q = FULL_TURN; plane_z_q = 0;
    nmode_q = 0; normal_z_q = 0; tex_en_q = 0;
    send_index(12'd0);
    send_index(12'd4);
    send_index(12'd16);      // past the point count, wraps
    send_index(12'd4095);
  endtask

  // field extremes and every normal mode
  task automatic test_directed;
    configure(16'd2, 16'hffff, 16'(FULL_TURN), 16'h8000, NRM_NONE, 16'h7fff, 1'b1);
    for (int m = 0; m < 16; m++) begin
      if (m != 0) begin
        drain();
        write_reg(REG_NORMAL_MODE, 16'(m));
        cfg_valid <= 1'b0;
      end
      send_index(IDX_W'(m % 3));
    end
    // open arc of zero sweep, zero radius, negative normal z
    configure(16'd1, 16'd0, 16'd0, 16'h7fff, NRM_NEG_SC, 16'h8000, 1'b0);
    send_index(12'd0);
    send_index(12'd4095);
    // oversized count and a sweep above a full turn
    configure(16'd8191, 16'h7fff, 16'hffff, 16'd0, NRM_CS, 16'd0, 1'b1);
    send_index(12'd4095);
    send_index(12'haaa);
    send_index(12'h555);
  endtask

  task automatic test_random_phases;
    for (int p = 0; p < 5; p++) begin
      random_config();
      repeat (40) send_index(random_index());
    end
  endtask

  // no idling on either side: back to back requests
  task automatic test_full_rate;
    random_config();
    steady = 1;
    repeat (80) send_index(random_index());
    drain();
    steady = 0;
  endtask

  // receiver holds off while the sender keeps offering, so the pipeline fills
  task automatic test_backpressure;
    random_config();
    hold_off_cycles = 300;
    repeat (120) send_index(random_index());
  endtask

  // sender waits for every vertex to come back before going on
  task automatic test_sender_pause;
    random_config();
    repeat (10) send_index(random_index());
    drain();
    repeat (10) send_index(random_index());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_phases();
    test_full_rate();
    test_backpressure();
    test_sender_pause();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d vertices checked: all normal modes, texture on and off,",
             requests_sent, vertices_checked);
    $display("clamped counts, wide sweeps, saturation, full rate and long output stalls");
    if (errors == 0 && pending_vertices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
